/* sv/mbc_pkg.sv */
// Shared constants, configuration and control types of the band coefficient core.
package mbc_pkg;

   // Geometry and sizing of the block.
   localparam int WINDOW_MAX  = 64;
   localparam int MAX_BANDS   = 8;
   localparam int TILE_SIZES  = 5;

   // Only five size enable bits exist, so larger tile sizes never run.
   localparam int SIZE_COUNT  = (TILE_SIZES < 5) ? TILE_SIZES : 5;
   localparam int SIZE_IDX_W  = (SIZE_COUNT > 1) ? $clog2(SIZE_COUNT) : 1;

   localparam int COORD_W     = $clog2(WINDOW_MAX + 1);
   localparam int ADDR_W      = $clog2(WINDOW_MAX * WINDOW_MAX);
   localparam int AREA_W      = $clog2(WINDOW_MAX * WINDOW_MAX + 1);
   localparam int PIXEL_W     = 8;
   localparam int BAND_W      = 3;
   localparam int NBANDS_W    = 4;
   localparam int LIMIT_W     = 9;
   localparam int LIMIT_IDX_W = $clog2(MAX_BANDS + 1);
   localparam int TOTAL_W     = 16;
   localparam int SQ_W        = 2 * TOTAL_W;
   localparam int SUM_W       = 36;
   localparam int COEF_W      = 16;
   localparam int QUO_W       = 2 * SQ_W;
   localparam int ROOT_W      = SQ_W + 2;
   localparam int DIV_STEPS   = QUO_W;
   localparam int SQRT_STEPS  = ROOT_W / 2;
   localparam int DIV_CNT_W   = $clog2(DIV_STEPS + 1);
   localparam int SQRT_CNT_W  = $clog2(SQRT_STEPS + 1);

   // Configuration port.
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 45;
   localparam int LOW_GROUP_W = 45;
   localparam int HIGH_GROUP_W = 36;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND_COUNT    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_MASK     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_LOW    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMITS_HIGH   = 3'd5;

   // Clamped configuration as the datapath sees it.
   typedef struct packed {
      logic [COORD_W-1:0]                   width;
      logic [COORD_W-1:0]                   height;
      logic [AREA_W-1:0]                    area;
      logic [NBANDS_W-1:0]                  bands;
      logic [4:0]                           size_mask;
      logic [MAX_BANDS:0][LIMIT_W-1:0]      limits;
   } cfg_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_en;
      logic window_start;
      logic scan_init;
      logic scan_step;
      logic band_store;
      logic band_next;
      logic band_rewind;
      logic div_start;
      logic sqrt_start;
      logic emit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic window_done;
      logic issue_last;
      logic band_last;
      logic sum_zero;
      logic div_idle;
      logic sqrt_idle;
      logic out_busy;
   } ctrl_status_type;

endpackage

/* sv/mbc_channels.sv */
// Stream interfaces for the pixel request channel and the coefficient response channel.
interface mbc_req_if;
   import mbc_pkg::*;
   logic               valid;
   logic               ready;
   logic [PIXEL_W-1:0] pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface mbc_rsp_if;
   import mbc_pkg::*;
   logic              valid;
   logic              ready;
   logic [BAND_W-1:0] band_index;
   logic [COEF_W-1:0] coefficient;
   logic              all_zero;
   logic              last;

   modport source (output valid, output band_index, output coefficient,
                   output all_zero, output last, input ready);
   modport sink   (input valid, input band_index, input coefficient,
                   input all_zero, input last, output ready);
endinterface

/* sv/mbc_csr.sv */
// Configuration registers with clamping of the geometry and band count.
module mbc_csr import mbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   logic [6:0]              width_ff;
   logic [6:0]              height_ff;
   logic [3:0]              bands_ff;
   logic [4:0]              mask_ff;
   logic [LOW_GROUP_W-1:0]  low_ff;
   logic [HIGH_GROUP_W-1:0] high_ff;
   logic [LOW_GROUP_W+HIGH_GROUP_W-1:0] all_limits;
   logic [COORD_W-1:0]      width_c;
   logic [COORD_W-1:0]      height_c;
   logic [NBANDS_W-1:0]     bands_c;

   // Register writes; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= 7'd64;
         height_ff <= 7'd64;
         bands_ff  <= 4'd1;
         mask_ff   <= 5'd1;
         low_ff    <= '0;
         high_ff   <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_WINDOW_WIDTH:  width_ff  <= csr_wdata[6:0];
            CSR_WINDOW_HEIGHT: height_ff <= csr_wdata[6:0];
            CSR_BAND_COUNT:    bands_ff  <= csr_wdata[3:0];
            CSR_SIZE_MASK:     mask_ff   <= csr_wdata[4:0];
            CSR_LIMITS_LOW:    low_ff    <= csr_wdata[LOW_GROUP_W-1:0];
            CSR_LIMITS_HIGH:   high_ff   <= csr_wdata[HIGH_GROUP_W-1:0];
            default: ;
         endcase
      end
   end

   // Zero reads as one, anything above the maximum saturates.
   always_comb begin
      if (width_ff == 7'd0)                 width_c = COORD_W'(1);
      else if (int'(width_ff) > WINDOW_MAX) width_c = COORD_W'(WINDOW_MAX);
      else                                  width_c = COORD_W'(width_ff);
      if (height_ff == 7'd0)                 height_c = COORD_W'(1);
      else if (int'(height_ff) > WINDOW_MAX) height_c = COORD_W'(WINDOW_MAX);
      else                                   height_c = COORD_W'(height_ff);
      if (bands_ff == 4'd0)                 bands_c = NBANDS_W'(1);
      else if (int'(bands_ff) > MAX_BANDS)  bands_c = NBANDS_W'(MAX_BANDS);
      else                                  bands_c = bands_ff;
   end

   assign all_limits    = {high_ff, low_ff};
   assign cfg.width     = width_c;
   assign cfg.height    = height_c;
   assign cfg.area      = AREA_W'(width_c) * AREA_W'(height_c);
   assign cfg.bands     = bands_c;
   assign cfg.size_mask = mask_ff;
   assign cfg.limits    = all_limits[(MAX_BANDS+1)*LIMIT_W-1:0];

endmodule

/* sv/mbc_ctrl.sv */
// Sequencer that steps through loading, tile scanning and normalization.
module mbc_ctrl import mbc_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  ctrl_status_type status,
   output ctrl_cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_LOAD, ST_INIT, ST_SCAN, ST_DRAIN, ST_STORE,
      ST_NORM, ST_DIV, ST_SQRT, ST_EMIT
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Command decode and next state.
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            cmd.load_en = 1'b1;
            if (status.window_done) begin
               cmd.window_start = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.scan_init = 1'b1;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.issue_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: state_in = ST_STORE;
         ST_STORE: begin
            cmd.band_store = 1'b1;
            if (status.band_last) begin
               cmd.band_rewind = 1'b1;
               state_in = ST_NORM;
            end else begin
               cmd.band_next = 1'b1;
               state_in = ST_INIT;
            end
         end
         ST_NORM: begin
            if (status.sum_zero) begin
               state_in = ST_EMIT;
            end else begin
               cmd.div_start = 1'b1;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (status.div_idle) begin
               cmd.sqrt_start = 1'b1;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: if (status.sqrt_idle) state_in = ST_EMIT;
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd.emit = 1'b1;
               if (status.band_last) begin
                  state_in = ST_LOAD;
               end else begin
                  cmd.band_next = 1'b1;
                  state_in = ST_NORM;
               end
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_LOAD;
      else       state_ff <= state_in;
   end

`ifndef SYNTHESIS
   // A scan step is never issued once the last one has gone out.
   a_scan_stops: assert property (@(posedge clock) disable iff (reset)
      (cmd.scan_step && status.issue_last) |=> !cmd.scan_step)
      else $error("scan continued past its last step");
   // Pixels are only taken while loading.
   a_load_only: assert property (@(posedge clock) disable iff (reset)
      cmd.load_en |-> !(cmd.scan_step || cmd.div_start || cmd.emit))
      else $error("load overlapped computation");
   // An emit never happens while the output register is full.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> !status.out_busy)
      else $error("emit into busy output");
`endif

endmodule

/* sv/mbc_datapath.sv */
// Window store, tile scanner, band totals, divider, square root and output register.
module mbc_datapath import mbc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  ctrl_cmd_type       cmd,
   output ctrl_status_type    status,
   input  logic               req_fire,
   input  logic [PIXEL_W-1:0] req_pixel,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BAND_W-1:0]  rsp_band_index,
   output logic [COEF_W-1:0]  rsp_coefficient,
   output logic               rsp_all_zero,
   output logic               rsp_last
);

   localparam int STORE_DEPTH = WINDOW_MAX * WINDOW_MAX;

   // Window store and load counter.
   logic [PIXEL_W-1:0] mem_ff [STORE_DEPTH];
   logic [PIXEL_W-1:0] rdata_ff;
   logic [ADDR_W-1:0]  pix_cnt_ff;
   logic [AREA_W-1:0]  pix_next;
   logic               window_full;

   // Scan iterator.
   logic [SIZE_IDX_W-1:0] k_ff;
   logic [COORD_W-1:0]    x0_ff, y0_ff, dx_ff, dy_ff;
   logic [COORD_W-1:0]    tile_s;
   logic [COORD_W:0]      x_far, y_far;
   logic [COORD_W-1:0]    row_addr, col_addr;
   logic [ADDR_W-1:0]     rd_addr;
   logic                  size_ok, dx_end, dy_end, tile_end, row_end, size_end;
   logic                  issue_last;

   // Check stage.
   logic                  chk_valid_ff, chk_tile_end_ff;
   logic                  tile_ok_ff;
   logic [TOTAL_W-1:0]    total_ff;
   logic signed [LIMIT_W:0] pix_s, lo_s, hi_s;
   logic                  in_band;
   logic [LIMIT_IDX_W-1:0] lo_idx, hi_idx;

   // Band totals and sum of squares.
   logic [TOTAL_W-1:0] totals_ff [MAX_BANDS];
   logic [BAND_W-1:0]  band_ff;
   logic [SUM_W-1:0]   sum_ff;
   logic [SQ_W-1:0]    total_sq, band_sq;

   // Divider and square root.
   logic [SUM_W-1:0]      rem_ff;
   logic [QUO_W-1:0]      quo_ff;
   logic [DIV_CNT_W-1:0]  div_cnt_ff;
   logic [SUM_W:0]        rem_shift;
   logic [ROOT_W-1:0]     sq_v_ff, sq_res_ff, sq_bit_ff;
   logic [SQRT_CNT_W-1:0] sqrt_cnt_ff;
   logic [ROOT_W:0]       sq_trial;

   // Output register.
   logic               out_valid_ff;
   logic [BAND_W-1:0]  out_band_ff;
   logic [COEF_W-1:0]  out_coef_ff;
   logic               out_zero_ff;
   logic               out_last_ff;
   logic [COEF_W-1:0]  coef_sat;

   // Pixel load: the window is complete once the count reaches the area.
   assign pix_next    = AREA_W'(pix_cnt_ff) + AREA_W'(1);
   assign window_full = pix_next >= cfg.area;

   always_ff @(posedge clock) begin
      if (reset) begin
         pix_cnt_ff <= '0;
      end else if (req_fire) begin
         pix_cnt_ff <= window_full ? '0 : pix_next[ADDR_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) mem_ff[pix_cnt_ff] <= req_pixel;
      if (cmd.scan_step && size_ok) rdata_ff <= mem_ff[rd_addr];
   end

   // Tile geometry for the current size and position.
   always_comb begin
      tile_s   = COORD_W'(k_ff) + COORD_W'(1);
      size_ok  = cfg.size_mask[k_ff] && (tile_s <= cfg.width) && (tile_s <= cfg.height);
      dx_end   = dx_ff == tile_s - COORD_W'(1);
      dy_end   = dy_ff == tile_s - COORD_W'(1);
      tile_end = dx_end && dy_end;
      x_far    = {1'b0, x0_ff} + {tile_s, 1'b0};
      y_far    = {1'b0, y0_ff} + {tile_s, 1'b0};
      row_end  = x_far > {1'b0, cfg.width};
      size_end = !size_ok || (tile_end && row_end && (y_far > {1'b0, cfg.height}));
      issue_last = size_end && (k_ff == SIZE_IDX_W'(SIZE_COUNT - 1));
      row_addr = y0_ff + dy_ff;
      col_addr = x0_ff + dx_ff;
      rd_addr  = ADDR_W'(row_addr) * ADDR_W'(cfg.width) + ADDR_W'(col_addr);
   end

   // Scan iterator: pixel within tile, then tile within grid, then size.
   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff  <= '0;
         x0_ff <= '0;
         y0_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
      end else if (cmd.scan_init) begin
         k_ff  <= '0;
         x0_ff <= '0;
         y0_ff <= '0;
         dx_ff <= '0;
         dy_ff <= '0;
      end else if (cmd.scan_step && !issue_last) begin
         priority if (size_end) begin
            k_ff  <= k_ff + SIZE_IDX_W'(1);
            x0_ff <= '0;
            y0_ff <= '0;
            dx_ff <= '0;
            dy_ff <= '0;
         end else if (tile_end) begin
            dx_ff <= '0;
            dy_ff <= '0;
            if (row_end) begin
               x0_ff <= '0;
               y0_ff <= y0_ff + tile_s;
            end else begin
               x0_ff <= x0_ff + tile_s;
            end
         end else if (dx_end) begin
            dx_ff <= '0;
            dy_ff <= dy_ff + COORD_W'(1);
         end else begin
            dx_ff <= dx_ff + COORD_W'(1);
         end
      end
   end

   // Band membership: lower limit exclusive, upper limit inclusive.
   assign lo_idx  = LIMIT_IDX_W'(band_ff);
   assign hi_idx  = LIMIT_IDX_W'(band_ff) + LIMIT_IDX_W'(1);
   assign pix_s   = signed'({2'b00, rdata_ff});
   assign lo_s    = signed'({cfg.limits[lo_idx][LIMIT_W-1], cfg.limits[lo_idx]});
   assign hi_s    = signed'({cfg.limits[hi_idx][LIMIT_W-1], cfg.limits[hi_idx]});
   assign in_band = (pix_s > lo_s) && (pix_s <= hi_s);

   // Check stage: a tile counts when every pixel is in band.
   always_ff @(posedge clock) begin
      if (reset) begin
         chk_valid_ff <= 1'b0;
         tile_ok_ff   <= 1'b1;
         total_ff     <= '0;
      end else if (cmd.scan_init) begin
         chk_valid_ff <= 1'b0;
         tile_ok_ff   <= 1'b1;
         total_ff     <= '0;
      end else begin
         chk_valid_ff <= cmd.scan_step && size_ok;
         if (chk_valid_ff) begin
            if (chk_tile_end_ff) begin
               tile_ok_ff <= 1'b1;
               if (tile_ok_ff && in_band && (total_ff != '1)) total_ff <= total_ff + TOTAL_W'(1);
            end else begin
               tile_ok_ff <= tile_ok_ff && in_band;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step) chk_tile_end_ff <= tile_end;
   end

   // Band bookkeeping and sum of squared totals.
   assign total_sq = total_ff * total_ff;
   assign band_sq  = totals_ff[band_ff] * totals_ff[band_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         band_ff <= '0;
         sum_ff  <= '0;
      end else begin
         if (cmd.window_start) begin
            band_ff <= '0;
            sum_ff  <= '0;
         end else if (cmd.band_rewind) begin
            band_ff <= '0;
         end else if (cmd.band_next) begin
            band_ff <= band_ff + BAND_W'(1);
         end
         if (cmd.band_store) sum_ff <= sum_ff + SUM_W'(total_sq);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.band_store) totals_ff[band_ff] <= total_ff;
   end

   // Restoring divider: (t*t << 32) / sum, one quotient bit per cycle.
   assign rem_shift = {rem_ff, quo_ff[QUO_W-1]};

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_start) begin
         div_cnt_ff <= DIV_CNT_W'(DIV_STEPS);
         rem_ff     <= '0;
         quo_ff     <= {band_sq, {SQ_W{1'b0}}};
      end else if (div_cnt_ff != '0) begin
         div_cnt_ff <= div_cnt_ff - DIV_CNT_W'(1);
         if (rem_shift >= {1'b0, sum_ff}) begin
            rem_ff <= SUM_W'(rem_shift - {1'b0, sum_ff});
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_shift[SUM_W-1:0];
            quo_ff <= {quo_ff[QUO_W-2:0], 1'b0};
         end
      end
   end

   // Digit-by-digit square root, two radicand bits per cycle.
   assign sq_trial = {1'b0, sq_res_ff} + {1'b0, sq_bit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_cnt_ff <= '0;
      end else if (cmd.sqrt_start) begin
         sqrt_cnt_ff <= SQRT_CNT_W'(SQRT_STEPS);
         sq_v_ff     <= quo_ff[ROOT_W-1:0];
         sq_res_ff   <= '0;
         sq_bit_ff   <= ROOT_W'(1) << (ROOT_W - 2);
      end else if (sqrt_cnt_ff != '0) begin
         sqrt_cnt_ff <= sqrt_cnt_ff - SQRT_CNT_W'(1);
         sq_bit_ff   <= sq_bit_ff >> 2;
         if ({1'b0, sq_v_ff} >= sq_trial) begin
            sq_v_ff   <= ROOT_W'({1'b0, sq_v_ff} - sq_trial);
            sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
         end else begin
            sq_res_ff <= sq_res_ff >> 1;
         end
      end
   end

   // Saturate a root of exactly one to the largest fraction.
   assign coef_sat = (sq_res_ff > ROOT_W'({COEF_W{1'b1}})) ? '1 : sq_res_ff[COEF_W-1:0];

   // Output register; it holds until the response transaction completes.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         out_band_ff <= band_ff;
         out_coef_ff <= status.sum_zero ? '0 : coef_sat;
         out_zero_ff <= status.sum_zero;
         out_last_ff <= status.band_last;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_band_index  = out_band_ff;
   assign rsp_coefficient = out_coef_ff;
   assign rsp_all_zero    = out_zero_ff;
   assign rsp_last        = out_last_ff;

   // Status back to the controller.
   assign status.window_done = req_fire && window_full;
   assign status.issue_last  = issue_last;
   assign status.band_last   = (NBANDS_W'(band_ff) + NBANDS_W'(1)) == cfg.bands;
   assign status.sum_zero    = sum_ff == '0;
   assign status.div_idle    = div_cnt_ff == '0;
   assign status.sqrt_idle   = sqrt_cnt_ff == '0;
   assign status.out_busy    = out_valid_ff;

`ifndef SYNTHESIS
   // The divider is never restarted while it runs.
   a_div_free: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> (div_cnt_ff == '0) && (sqrt_cnt_ff == '0))
      else $error("divider restarted while busy");
   // The finished root never exceeds one in Q0.16.
   a_root_range: assert property (@(posedge clock) disable iff (reset)
      ($past(sqrt_cnt_ff) == SQRT_CNT_W'(1)) && (sqrt_cnt_ff == '0) |->
      sq_res_ff <= (ROOT_W'(1) << COEF_W))
      else $error("square root out of range");
   // The remainder always stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (div_cnt_ff != '0) && !$past(cmd.div_start) |-> rem_ff < sum_ff)
      else $error("divider remainder out of range");
`endif

endmodule

/* sv/morphological_band_coefficient_core.sv */
// Top level of the morphological band coefficient core.
//
//   channel   direction  payload                                  handshake
//   req_chan  in         pixel[7:0]                               valid/ready
//   rsp_chan  out        band_index[2:0] coefficient[15:0]        valid/ready
//                        all_zero last
//   csr_*     in         csr_index[2:0] csr_wdata[44:0]           csr_write_en
//
// Pixels load at one per cycle while the controller is loading; the pixel that completes
// the window starts the evaluation. Each band then scans every pixel of every whole enabled
// tile once through the single read port of the window store. Each band result then passes
// through the divider and the square root, or skips both when all totals are zero.
// Reset is synchronous and clears control state; the window store is not cleared.
// A stalled response holds in the output register while the next window loads.
module morphological_band_coefficient_core import mbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbc_req_if.sink               req_chan,
   mbc_rsp_if.source             rsp_chan,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type         cfg;
   ctrl_cmd_type    cmd;
   ctrl_status_type status;
   logic            req_fire;

   // A request transaction completes while the controller is loading.
   assign req_chan.ready = cmd.load_en;
   assign req_fire       = req_chan.valid && cmd.load_en;

   mbc_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   mbc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   mbc_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_fire        (req_fire),
      .req_pixel       (req_chan.pixel),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_band_index  (rsp_chan.band_index),
      .rsp_coefficient (rsp_chan.coefficient),
      .rsp_all_zero    (rsp_chan.all_zero),
      .rsp_last        (rsp_chan.last)
   );

endmodule

/* verif/mbc_checker.sv */
// Watches the pixel, coefficient and register ports, predicts every band result and compares it.
module mbc_checker import mbc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbc_req_if                    req_mon,
   mbc_rsp_if                    rsp_mon,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    error_count,
   output int                    pending_count
);

   typedef struct {
      logic [BAND_W-1:0] band_index;
      logic [COEF_W-1:0] coefficient;
      logic              all_zero;
      logic              last;
   } band_result_type;

   band_result_type     band_results_due[$];
   logic [PIXEL_W-1:0]  window_pixels [WINDOW_MAX*WINDOW_MAX];
   int                  pixels_received;

   // Local copy of the register file.
   logic [6:0]              reg_width;
   logic [6:0]              reg_height;
   logic [3:0]              reg_bands;
   logic [4:0]              reg_size_mask;
   logic [LOW_GROUP_W-1:0]  reg_limits_low;
   logic [HIGH_GROUP_W-1:0] reg_limits_high;

   function automatic int clamp_count(int v, int hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
   endfunction

   function automatic int grey_limit(int i);
      logic [LIMIT_W-1:0] raw;
      int                 value;
      raw = (i < 5) ? reg_limits_low[LIMIT_W*i +: LIMIT_W]
                    : reg_limits_high[LIMIT_W*(i-5) +: LIMIT_W];
      value = $signed(raw);
      return value;
   endfunction

   // A tile counts only when every one of its pixels falls in (lo, hi].
   function automatic bit tile_in_band(int x0, int y0, int s, int w, int lo, int hi);
      int p;
      for (int y = 0; y < s; y++) begin
         for (int x = 0; x < s; x++) begin
            p = window_pixels[(y0 + y) * w + x0 + x];
            if (!(p > lo && p <= hi)) return 0;
         end
      end
      return 1;
   endfunction

   function automatic int band_tile_total(int b, int w, int h);
      int lo;
      int hi;
      int total;
      lo = grey_limit(b);
      hi = grey_limit(b + 1);
      total = 0;
      for (int k = 0; k < SIZE_COUNT; k++) begin
         if (reg_size_mask[k]) begin
            // Only whole tiles are visited; partial tiles at the edges never count.
            for (int y0 = 0; y0 + k + 1 <= h; y0 += k + 1)
               for (int x0 = 0; x0 + k + 1 <= w; x0 += k + 1)
                  if (tile_in_band(x0, y0, k + 1, w, lo, hi) && total < 65535)
                     total++;
         end
      end
      return total;
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned root;
      longint unsigned probe;
      root = 0;
      probe = 64'd1 << 62;
      while (probe > v) probe >>= 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v -= root + probe;
            root = (root >> 1) + probe;
         end else begin
            root >>= 1;
         end
         probe >>= 2;
      end
      return root;
   endfunction

   // Evaluates a completed window and queues one result per band.
   function automatic void queue_band_results(int w, int h);
      int              nb;
      longint unsigned totals [MAX_BANDS];
      longint unsigned energy;
      longint unsigned ratio;
      longint unsigned coef;
      band_result_type r;
      nb = clamp_count(reg_bands, MAX_BANDS);
      energy = 0;
      for (int b = 0; b < nb; b++) begin
         totals[b] = band_tile_total(b, w, h);
         energy += totals[b] * totals[b];
      end
      for (int b = 0; b < nb; b++) begin
         coef = 0;
         if (energy != 0) begin
            ratio = ((totals[b] * totals[b]) << 32) / energy;
            coef = floor_sqrt(ratio);
            if (coef > 65535) coef = 65535;
         end
         r.band_index = b[BAND_W-1:0];
         r.coefficient = coef[COEF_W-1:0];
         r.all_zero = (energy == 0);
         r.last = (b + 1 == nb);
         band_results_due.push_back(r);
      end
   endfunction

   // Monitor all ports at each rising edge, before the block's registers update.
   always @(posedge clock) begin
      band_result_type want;
      int              w;
      int              h;
      if (reset) begin
         reg_width = 7'd64;
         reg_height = 7'd64;
         reg_bands = 4'd1;
         reg_size_mask = 5'd1;
         reg_limits_low = '0;
         reg_limits_high = '0;
         pixels_received = 0;
         error_count = 0;
         band_results_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               CSR_WINDOW_WIDTH:  reg_width = csr_wdata[6:0];
               CSR_WINDOW_HEIGHT: reg_height = csr_wdata[6:0];
               CSR_BAND_COUNT:    reg_bands = csr_wdata[3:0];
               CSR_SIZE_MASK:     reg_size_mask = csr_wdata[4:0];
               CSR_LIMITS_LOW:    reg_limits_low = csr_wdata[LOW_GROUP_W-1:0];
               CSR_LIMITS_HIGH:   reg_limits_high = csr_wdata[HIGH_GROUP_W-1:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            w = clamp_count(reg_width, WINDOW_MAX);
            h = clamp_count(reg_height, WINDOW_MAX);
            if (pixels_received < WINDOW_MAX * WINDOW_MAX)
               window_pixels[pixels_received] = req_mon.pixel;
            pixels_received++;
            if (pixels_received >= w * h) begin
               pixels_received = 0;
               queue_band_results(w, h);
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (band_results_due.size() == 0) begin
               $error("coefficient transaction with no result outstanding");
               error_count++;
            end else begin
               want = band_results_due.pop_front();
               if (rsp_mon.band_index !== want.band_index) begin
                  $error("band_index expected %0d actual %0d", want.band_index,
                         rsp_mon.band_index);
                  error_count++;
               end
               if (rsp_mon.coefficient !== want.coefficient) begin
                  $error("coefficient expected %0d actual %0d", want.coefficient,
                         rsp_mon.coefficient);
                  error_count++;
               end
               if (rsp_mon.all_zero !== want.all_zero) begin
                  $error("all_zero expected %0d actual %0d", want.all_zero,
                         rsp_mon.all_zero);
                  error_count++;
               end
               if (rsp_mon.last !== want.last) begin
                  $error("last expected %0d actual %0d", want.last, rsp_mon.last);
                  error_count++;
               end
            end
         end
      end
      pending_count = band_results_due.size();
   end

endmodule

/* verif/testbench.sv */
// Stimulus and verdict for the band coefficient core: windows, register settings, flow control.
module testbench;
   import mbc_pkg::*;

   localparam int CYCLE_LIMIT     = 4000000;
   localparam int HOLD_OFF_CYCLES = 3000;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int error_count;
   int pending_count;
   int pixel_idle_pct;
   int ready_idle_pct;
   int stall_cycles_left;
   int hold_off_requests;
   int hold_off_served;
   int window_pixels;
   int cycle_count;

   mbc_req_if req ();
   mbc_rsp_if rsp ();

   morphological_band_coefficient_core DUT (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req),
      .rsp_chan     (rsp),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   mbc_checker band_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req),
      .rsp_mon       (rsp),
      .csr_write_en  (csr_write_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Response flow control: random back-pressure, or a long hold-off when requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         stall_cycles_left <= 0;
         hold_off_served <= hold_off_requests;
      end else if (hold_off_served != hold_off_requests) begin
         hold_off_served <= hold_off_requests;
         stall_cycles_left <= HOLD_OFF_CYCLES;
         rsp.ready <= 1'b0;
      end else if (stall_cycles_left > 0) begin
         rsp.ready <= 1'b0;
         stall_cycles_left <= stall_cycles_left - 1;
      end else begin
         rsp.ready <= ($urandom_range(0, 99) >= ready_idle_pct);
      end
   end

   // Timeout guard.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TEST FAILED");
      $finish;
   end

   // Packs nine grey limits into the two limit registers (low group in the low bits).
   function automatic logic [80:0] pack_limits(int lim [9]);
      logic [80:0] packed_limits;
      for (int i = 0; i < 9; i++) packed_limits[9*i +: 9] = lim[i][8:0];
      return packed_limits;
   endfunction

   function automatic logic [80:0] random_limits();
      int lim [9];
      int level;
      if ($urandom_range(0, 99) < 15)
         return 81'({$urandom, $urandom, $urandom});
      level = $urandom_range(0, 80) - 40;
      for (int i = 0; i < 9; i++) begin
         lim[i] = (level > 255) ? 255 : level;
         level += $urandom_range(0, 70);
      end
      return pack_limits(lim);
   endfunction

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Waits until the block has drained, then rewrites every register.
   task automatic apply_config(int w, int h, int nb, int mask, logic [80:0] limits);
      int wc;
      int hc;
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      write_reg(CSR_WINDOW_WIDTH, CSR_DATA_W'(w));
      write_reg(CSR_WINDOW_HEIGHT, CSR_DATA_W'(h));
      write_reg(CSR_BAND_COUNT, CSR_DATA_W'(nb));
      write_reg(CSR_SIZE_MASK, CSR_DATA_W'(mask));
      write_reg(CSR_LIMITS_LOW, limits[44:0]);
      write_reg(CSR_LIMITS_HIGH, {9'd0, limits[80:45]});
      csr_write_en <= 1'b0;
      wc = (w == 0) ? 1 : (w > WINDOW_MAX) ? WINDOW_MAX : w;
      hc = (h == 0) ? 1 : (h > WINDOW_MAX) ? WINDOW_MAX : h;
      window_pixels = wc * hc;
   endtask

   task automatic send_pixel(logic [PIXEL_W-1:0] value);
      while ($urandom_range(0, 99) < pixel_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.pixel <= value;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   // One whole window; pixels come mostly from a small palette so that tiles fill up.
   task automatic send_window(bit uniform);
      logic [PIXEL_W-1:0] palette [3];
      for (int i = 0; i < 3; i++) palette[i] = PIXEL_W'($urandom_range(0, 255));
      for (int i = 0; i < window_pixels; i++) begin
         if (uniform) send_pixel(palette[0]);
         else if ($urandom_range(0, 3) != 0) send_pixel(palette[$urandom_range(0, 2)]);
         else send_pixel(PIXEL_W'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int lim [9];
      int sent;
      int w;
      int h;
      reset = 1'b1;
      csr_write_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.pixel = '0;
      pixel_idle_pct = 0;
      ready_idle_pct = 0;
      hold_off_requests = 0;
      window_pixels = WINDOW_MAX * WINDOW_MAX;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Full-width window with every pixel inside the first band: coefficient saturates.
      lim = '{-1, 255, 255, 255, 255, 255, 255, 255, 255};
      apply_config(64, 4, 2, 31, pack_limits(lim));
      send_window(0);

      // Zero width, height and band count act as one; lowest limit at -256.
      lim = '{-256, 0, 0, 0, 0, 0, 0, 0, 0};
      apply_config(0, 0, 0, 1, pack_limits(lim));
      send_pixel(8'd0);
      send_pixel(8'd255);

      // Oversized width and band count saturate; one band per stretch of grey levels.
      lim = '{-1, 31, 63, 95, 127, 159, 191, 223, 255};
      apply_config(127, 1, 15, 31, pack_limits(lim));
      for (int i = 0; i < 64; i++) send_pixel(PIXEL_W'(i * 4 + 3));

      // Window not a multiple of the larger tiles, so edge tiles must be dropped.
      apply_config(7, 5, 3, 31, pack_limits(lim));
      send_window(1);

      // No tile size enabled, then limits that leave every band empty.
      apply_config(2, 2, 4, 0, pack_limits(lim));
      send_window(0);
      apply_config(3, 3, 8, 31, {81{1'b1}});
      send_window(1);
      apply_config(3, 2, 8, 31, '0);
      send_window(0);

      // Random part, under three flow-control modes.
      for (int mode = 0; mode < 3; mode++) begin
         pixel_idle_pct = (mode == 0) ? 9 : (mode == 1) ? 79 : 0;
         ready_idle_pct = (mode == 0) ? 79 : (mode == 1) ? 9 : 0;
         sent = 0;
         if (mode == 2) begin
            // Long response hold-off while windows keep arriving.
            lim = '{-1, 31, 63, 95, 127, 159, 191, 223, 255};
            apply_config(4, 4, 8, 31, pack_limits(lim));
            hold_off_requests++;
            for (int i = 0; i < 4; i++) send_window(0);
         end
         while (sent < 40) begin
            w = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            h = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 8);
            apply_config(w, h, $urandom_range(0, 15), $urandom_range(0, 31), random_limits());
            for (int i = $urandom_range(1, 4); i > 0; i--) begin
               send_window($urandom_range(0, 4) == 0);
               sent += window_pixels;
            end
         end
      end
      req.valid <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule

/* files.f */
sv/mbc_pkg.sv
sv/mbc_channels.sv
sv/mbc_csr.sv
sv/mbc_ctrl.sv
sv/mbc_datapath.sv
sv/morphological_band_coefficient_core.sv
verif/mbc_checker.sv
verif/testbench.sv
